FILE: rtl/cstg_pkg.sv
// ----------------------------------------------------------------------------
// cstg_pkg: shared types and constants of the cadenced sine tone generator
// Item formats, tone and opcode codes, register indexes and the sine ROM.
// ----------------------------------------------------------------------------
package cstg_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int IDX_W          = $clog2(TABLE_SIZE);
    localparam int PHASE_FRACTION = 16;
    localparam int AMPLITUDE      = 8000;
    localparam int PHASE_W        = 32;
    localparam int CNT_W          = 20;
    localparam int INC_W          = 24;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int SAMPLE_W       = 16;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIAL_INC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_INC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYPRESS_INC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYPRESS_LEN = 3'd5;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_DIAL = 2'd1,
        MODE_BUSY = 2'd2,
        MODE_KEY  = 2'd3
    } t_tone;

    typedef struct packed {
        logic       opcode;
        logic [1:0] tone_select;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [1:0]                 current_tone;
    } t_out_item;

    typedef struct packed {
        t_tone              mode;
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   cnt;
    } t_state;

    // remainder unit handshake
    typedef struct packed {
        logic start;
        logic abort;
    } t_rem_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

    // ---- sine ROM, built at elaboration (fixed-point Taylor series, Q30) ----
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [12] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    typedef logic [TABLE_SIZE-1:0][SAMPLE_W-1:0] t_sine_rom;

    function automatic logic [SAMPLE_W-1:0] sine_entry(input longint unsigned t);
        longint unsigned x;
        longint unsigned term;
        longint unsigned mag;
        longint          sum;
        logic            neg;
        x   = (64'd2 * PI_Q30 * t + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
        neg = 1'b0;
        if (x >= PI_Q30) begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q30) begin
            x = PI_Q30 - x;
        end
        sum  = longint'(x);
        term = x;
        for (int k = 1; k <= 12; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[k-1];
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        mag = (longint'(unsigned'(sum)) * 64'(AMPLITUDE) + 64'd536870912) >> 30;
        if (mag > 64'(AMPLITUDE)) begin
            mag = 64'(AMPLITUDE);
        end
        return neg ? SAMPLE_W'(64'd0 - mag) : SAMPLE_W'(mag);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/cstg_rem.sv
// ----------------------------------------------------------------------------
// cstg_rem: sequential remainder unit
// Restoring remainder of a counter value by the busy period, one bit a cycle.
// ----------------------------------------------------------------------------
module cstg_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cstg_pkg::t_rem_ctrl        i_ctrl,
    input  logic [cstg_pkg::CNT_W-1:0] i_dividend,
    input  logic [cstg_pkg::CNT_W-1:0] i_divisor,
    output cstg_pkg::t_rem_stat        o_stat,
    output logic [cstg_pkg::CNT_W-1:0] o_remainder
);
    import cstg_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    shifted;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_num[CNT_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = CNT_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.abort) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem  <= n_rem;
            r_num  <= {r_num[CNT_W-2:0], 1'b0};
            r_step <= r_step - STEP_W'(1);
        end else if (i_ctrl.start) begin
            r_rem  <= '0;
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_step <= STEP_W'(CNT_W - 1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/cadenced_sine_tone_generator_top.sv
// ----------------------------------------------------------------------------
// cadenced_sine_tone_generator_top: telephone tone generator
// Throughput: one item per cycle unless the output stalls or a busy tick waits
// for the remainder unit; the tone state is read from a one-entry synchronous
// memory with write-back bypass, then the sine ROM is read. A busy tick whose
// counter is at or above the busy period (after a period rewrite) waits for
// the sequential remainder unit.
// Reset (synchronous, active low) clears registers, tone state and pipeline.
// ----------------------------------------------------------------------------
module cadenced_sine_tone_generator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  cstg_pkg::t_in_item             i_in_item,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output cstg_pkg::t_out_item            o_out_item,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [cstg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cstg_pkg::CFG_W-1:0]     i_cfg_data
);
    import cstg_pkg::*;

    // configuration registers
    logic [INC_W-1:0] r_dial_inc;
    logic [INC_W-1:0] r_busy_inc;
    logic [INC_W-1:0] r_key_inc;
    logic [CNT_W-1:0] r_busy_on;
    logic [CNT_W-1:0] r_busy_period;
    logic [CNT_W-1:0] r_key_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dial_inc    <= '0;
            r_busy_inc    <= '0;
            r_key_inc     <= '0;
            r_busy_on     <= '0;
            r_busy_period <= '0;
            r_key_len     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIAL_INC:     r_dial_inc    <= i_cfg_data[INC_W-1:0];
                CFG_BUSY_INC:     r_busy_inc    <= i_cfg_data[INC_W-1:0];
                CFG_KEYPRESS_INC: r_key_inc     <= i_cfg_data[INC_W-1:0];
                CFG_BUSY_ON:      r_busy_on     <= i_cfg_data[CNT_W-1:0];
                CFG_BUSY_PERIOD:  r_busy_period <= i_cfg_data[CNT_W-1:0];
                CFG_KEYPRESS_LEN: r_key_len     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- tone state memory: one entry, registered read, write-back bypass ----
    t_state r_state_mem [1];
    logic   r_mem_valid;
    t_state r_state_rd;
    logic   r_byp_hit;
    t_state r_byp_data;
    t_state cur;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_state_mem[0] <= n_state;
        end
        r_byp_data <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
            r_byp_hit   <= 1'b0;
            r_state_rd  <= '0;
        end else begin
            if (accept) begin
                r_mem_valid <= 1'b1;
            end
            r_byp_hit  <= accept;
            r_state_rd <= r_mem_valid ? r_state_mem[0] : '0;
        end
    end

    assign cur = r_byp_hit ? r_byp_data : r_state_rd;

    // ---- remainder of the counter by the busy period, when it is needed ----
    t_rem_ctrl        rem_ctrl;
    t_rem_stat        rem_stat;
    logic [CNT_W-1:0] rem_out;
    logic             r_rem_valid;
    logic [CNT_W-1:0] r_rem;
    logic             is_tick;
    logic             cnt_ge_period;
    logic             need_rem;
    logic             rem_wait;

    assign is_tick       = (i_in_item.opcode == OP_TICK);
    assign cnt_ge_period = (cur.cnt >= r_busy_period);
    assign need_rem      = i_in_valid && is_tick && (cur.mode == MODE_BUSY)
                           && (r_busy_period != '0) && cnt_ge_period;
    assign rem_wait      = need_rem && !r_rem_valid;

    assign rem_ctrl.start = rem_wait && !rem_stat.busy && !rem_stat.done;
    assign rem_ctrl.abort = i_cfg_we;

    cstg_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (rem_ctrl),
        .i_dividend  (cur.cnt),
        .i_divisor   (r_busy_period),
        .o_stat      (rem_stat),
        .o_remainder (rem_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || accept) begin
            r_rem_valid <= 1'b0;
        end else if (rem_stat.done) begin
            r_rem_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rem_stat.done) begin
            r_rem <= rem_out;
        end
    end

    // ---- pipeline control ----
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load;
    logic s1_load;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || out_load;
    assign o_in_stall = !s1_load || rem_wait;
    assign accept     = i_in_valid && !o_in_stall;

    // ---- next state and sample selection ----
    logic [CNT_W-1:0] cnt_sat;
    logic [CNT_W-1:0] busy_rem;
    logic [INC_W-1:0] step;
    logic             audible;

    always_comb begin
        cnt_sat  = (cur.cnt == '1) ? cur.cnt : cur.cnt + CNT_W'(1);
        busy_rem = cnt_ge_period ? r_rem : cur.cnt;
        n_state  = cur;
        audible  = 1'b0;
        step     = '0;
        if (i_in_item.opcode == OP_SELECT) begin
            n_state.mode  = t_tone'(i_in_item.tone_select);
            n_state.phase = '0;
            n_state.cnt   = '0;
        end else begin
            case (cur.mode)
                MODE_DIAL: begin
                    audible     = 1'b1;
                    step        = r_dial_inc;
                    n_state.cnt = cnt_sat;
                end
                MODE_BUSY: begin
                    step = r_busy_inc;
                    if (r_busy_period != '0) begin
                        audible = (busy_rem < r_busy_on);
                        if (({1'b0, cur.cnt} + (CNT_W+1)'(1)) >= {1'b0, r_busy_period}) begin
                            n_state.cnt = '0;
                        end else begin
                            n_state.cnt = cur.cnt + CNT_W'(1);
                        end
                    end else begin
                        n_state.cnt = cnt_sat;
                    end
                end
                MODE_KEY: begin
                    step = r_key_inc;
                    if (cur.cnt >= r_key_len) begin
                        n_state.mode = MODE_OFF;
                    end else begin
                        audible = 1'b1;
                    end
                    n_state.cnt = cnt_sat;
                end
                default: begin
                    n_state.cnt = cnt_sat;
                end
            endcase
            if (audible) begin
                n_state.phase = cur.phase + PHASE_W'(step);
            end
        end
    end

    // ---- stage 1: ROM address ----
    logic             r_s1_audible;
    logic [IDX_W-1:0] r_s1_idx;
    t_tone            r_s1_tone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= accept && is_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_tick) begin
            r_s1_audible <= audible;
            r_s1_idx     <= cur.phase[PHASE_FRACTION +: IDX_W];
            r_s1_tone    <= n_state.mode;
        end
    end

    // ---- output register: ROM lookup ----
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_item.sample       <= r_s1_audible ? SINE_ROM[r_s1_idx] : '0;
            r_out_item.current_tone <= r_s1_tone;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/cstg_checker.sv
// ----------------------------------------------------------------------------
// cstg_checker: port-level checks of the tone generator
// Watches the top level's ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module cstg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input cstg_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);
    import cstg_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] AMP_S = SAMPLE_W'(AMPLITUDE);

    // a result reporting no tone is always silent
    a_none_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.current_tone == MODE_OFF) |-> o_out_item.sample == '0)
        else $error("nonzero sample with no tone");

    a_amplitude: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.sample <= AMP_S) && (o_out_item.sample >= -AMP_S))
        else $error("sample beyond amplitude");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind cadenced_sine_tone_generator_top cstg_checker u_cstg_checker (.*);
